/* rtl/rap_pkg.sv */
package rap_pkg;

  // lexeme codes
  localparam logic [3:0] TK_NONE    = 4'd0;
  localparam logic [3:0] TK_UNKNOWN = 4'd1;
  localparam logic [3:0] TK_ACTION  = 4'd2;
  localparam logic [3:0] TK_LPAREN  = 4'd3;
  localparam logic [3:0] TK_RPAREN  = 4'd4;
  localparam logic [3:0] TK_BAR     = 4'd5;
  localparam logic [3:0] TK_STAR    = 4'd6;
  localparam logic [3:0] TK_PLUS    = 4'd7;
  localparam logic [3:0] TK_QUEST   = 4'd8;
  localparam logic [3:0] TK_CHAR    = 4'd9;
  localparam logic [3:0] TK_LBRACE  = 4'd10;
  localparam logic [3:0] TK_RBRACE  = 4'd11;
  localparam logic [3:0] TK_COMPL   = 4'd12;
  localparam logic [3:0] TK_CLASS   = 4'd13;

  // grammar terminals
  localparam logic [3:0] TM_END    = 4'd0;
  localparam logic [3:0] TM_ACT    = 4'd1;
  localparam logic [3:0] TM_BAR    = 4'd2;
  localparam logic [3:0] TM_POST   = 4'd3;
  localparam logic [3:0] TM_LEAF   = 4'd4;
  localparam logic [3:0] TM_LBRACE = 4'd5;
  localparam logic [3:0] TM_RBRACE = 4'd6;
  localparam logic [3:0] TM_LPAREN = 4'd7;
  localparam logic [3:0] TM_RPAREN = 4'd8;

  // command kinds
  localparam logic [2:0] CK_CHAR  = 3'd0;
  localparam logic [2:0] CK_CLASS = 3'd1;
  localparam logic [2:0] CK_COMPL = 3'd2;
  localparam logic [2:0] CK_CAT   = 3'd3;
  localparam logic [2:0] CK_OR    = 3'd4;
  localparam logic [2:0] CK_STAR  = 3'd5;
  localparam logic [2:0] CK_PLUS  = 3'd6;
  localparam logic [2:0] CK_QUEST = 3'd7;

  // parser states
  localparam logic [4:0] PS_START  = 5'd0;
  localparam logic [4:0] PS_DONE   = 5'd1;
  localparam logic [4:0] PS_LBRACE = 5'd2;
  localparam logic [4:0] PS_BODY   = 5'd3;
  localparam logic [4:0] PS_E      = 5'd4;
  localparam logic [4:0] PS_F      = 5'd5;
  localparam logic [4:0] PS_G      = 5'd6;
  localparam logic [4:0] PS_H      = 5'd7;
  localparam logic [4:0] PS_LEAF   = 5'd8;
  localparam logic [4:0] PS_LPAREN = 5'd9;
  localparam logic [4:0] PS_BAR    = 5'd10;
  localparam logic [4:0] PS_RBRACE = 5'd11;
  localparam logic [4:0] PS_EF     = 5'd12;
  localparam logic [4:0] PS_GPOST  = 5'd13;
  localparam logic [4:0] PS_HACT   = 5'd14;
  localparam logic [4:0] PS_INNER  = 5'd15;
  localparam logic [4:0] PS_ALT    = 5'd16;
  localparam logic [4:0] PS_RPAREN = 5'd17;

  // rules
  localparam logic [3:0] R_ACCEPT = 4'd0;
  localparam logic [3:0] R_OR     = 4'd1;
  localparam logic [3:0] R_T_E    = 4'd2;
  localparam logic [3:0] R_CAT    = 4'd3;
  localparam logic [3:0] R_E_F    = 4'd4;
  localparam logic [3:0] R_POST   = 4'd5;
  localparam logic [3:0] R_F_G    = 4'd6;
  localparam logic [3:0] R_ACT    = 4'd7;
  localparam logic [3:0] R_G_H    = 4'd8;
  localparam logic [3:0] R_LEAF   = 4'd9;
  localparam logic [3:0] R_PAREN  = 4'd10;

  // action byte: kind in [7:6], argument in [4:0]
  localparam logic [1:0] AK_ER  = 2'd0;
  localparam logic [1:0] AK_SH  = 2'd1;
  localparam logic [1:0] AK_RD  = 2'd2;
  localparam logic [1:0] AK_ACC = 2'd3;

  localparam logic [7:0] ER  = {AK_ER, 6'd0};
  localparam logic [7:0] ACC = {AK_ACC, 6'd0};

  localparam logic [7:0] FILL_CHAR = 8'h61;

  localparam int NSTATES = 18;
  localparam int NTERMS  = 9;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  char_value;
    logic [15:0] set_index;
    logic [15:0] action_index;
    logic        action_defined;
    logic        is_action_kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  cmd_kind;
    logic [7:0]  cmd_char;
    logic [15:0] cmd_set;
    logic [5:0]  cmd_first;
    logic [5:0]  cmd_second;
    logic [15:0] cmd_action;
    logic        last;
    logic [7:0]  error_total;
    logic        overflow;
  } out_item_t;

  function automatic logic [7:0] a_sh(logic [4:0] s);
    return {AK_SH, 1'b0, s};
  endfunction

  function automatic logic [7:0] a_rd(logic [3:0] r);
    return {AK_RD, 2'b00, r};
  endfunction

  localparam logic [3:0] TERM_OF [0:15] = '{
    TM_END, TM_END, TM_ACT, TM_LPAREN, TM_RPAREN, TM_BAR, TM_POST, TM_POST,
    TM_POST, TM_LEAF, TM_LBRACE, TM_RBRACE, TM_LEAF, TM_LEAF, TM_END, TM_END
  };

  localparam logic [1:0] RULE_LEN [0:10] = '{
    2'd3, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd3
  };

  localparam logic [7:0] ACT_TBL [0:NSTATES-1][0:NTERMS-1] = '{
    '{ER, ER, ER, ER, ER, a_sh(PS_LBRACE), ER, ER, ER},
    '{ACC, ER, ER, ER, ER, ER, ER, ER, ER},
    '{ER, ER, ER, ER, a_sh(PS_LEAF), ER, ER, a_sh(PS_LPAREN), ER},
    '{ER, ER, a_sh(PS_BAR), ER, ER, ER, a_sh(PS_RBRACE), ER, ER},
    '{ER, ER, a_rd(R_T_E), ER, a_sh(PS_LEAF), ER, a_rd(R_T_E), a_sh(PS_LPAREN),
      a_rd(R_T_E)},
    '{ER, ER, a_rd(R_E_F), ER, a_rd(R_E_F), ER, a_rd(R_E_F), a_rd(R_E_F),
      a_rd(R_E_F)},
    '{ER, ER, a_rd(R_F_G), a_sh(PS_GPOST), a_rd(R_F_G), ER, a_rd(R_F_G),
      a_rd(R_F_G), a_rd(R_F_G)},
    '{ER, a_sh(PS_HACT), a_rd(R_G_H), a_rd(R_G_H), a_rd(R_G_H), ER, a_rd(R_G_H),
      a_rd(R_G_H), a_rd(R_G_H)},
    '{ER, a_rd(R_LEAF), a_rd(R_LEAF), a_rd(R_LEAF), a_rd(R_LEAF), ER,
      a_rd(R_LEAF), a_rd(R_LEAF), a_rd(R_LEAF)},
    '{ER, ER, ER, ER, a_sh(PS_LEAF), ER, ER, a_sh(PS_LPAREN), ER},
    '{ER, ER, ER, ER, a_sh(PS_LEAF), ER, ER, a_sh(PS_LPAREN), ER},
    '{a_rd(R_ACCEPT), ER, ER, ER, ER, ER, ER, ER, ER},
    '{ER, ER, a_rd(R_CAT), ER, a_rd(R_CAT), ER, a_rd(R_CAT), a_rd(R_CAT),
      a_rd(R_CAT)},
    '{ER, ER, a_rd(R_POST), ER, a_rd(R_POST), ER, a_rd(R_POST), a_rd(R_POST),
      a_rd(R_POST)},
    '{ER, ER, a_rd(R_ACT), a_rd(R_ACT), a_rd(R_ACT), ER, a_rd(R_ACT),
      a_rd(R_ACT), a_rd(R_ACT)},
    '{ER, ER, a_sh(PS_BAR), ER, ER, ER, ER, ER, a_sh(PS_RPAREN)},
    '{ER, ER, a_rd(R_OR), ER, a_sh(PS_LEAF), ER, a_rd(R_OR), a_sh(PS_LPAREN),
      a_rd(R_OR)},
    '{ER, a_rd(R_PAREN), a_rd(R_PAREN), a_rd(R_PAREN), a_rd(R_PAREN), ER,
      a_rd(R_PAREN), a_rd(R_PAREN), a_rd(R_PAREN)}
  };

  // reduction taken when the lookahead is not in the table
  function automatic logic [3:0] forced_rule(logic [4:0] st);
    logic [3:0] r;
    r = R_ACCEPT;
    case (st)
      PS_E:      r = R_T_E;
      PS_F:      r = R_E_F;
      PS_G:      r = R_F_G;
      PS_H:      r = R_G_H;
      PS_LEAF:   r = R_LEAF;
      PS_EF:     r = R_CAT;
      PS_GPOST:  r = R_POST;
      PS_HACT:   r = R_ACT;
      PS_ALT:    r = R_OR;
      PS_RPAREN: r = R_PAREN;
      default:   r = R_ACCEPT;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] goto_state(logic [3:0] r, logic [4:0] s);
    logic [4:0] g;
    case (r)
      R_ACCEPT:      g = PS_DONE;
      R_OR, R_T_E:   g = (s == PS_LPAREN) ? PS_INNER : PS_BODY;
      R_CAT, R_E_F:  g = (s == PS_BAR) ? PS_ALT : PS_E;
      R_POST, R_F_G: g = (s == PS_E || s == PS_ALT) ? PS_EF : PS_F;
      R_ACT, R_G_H:  g = PS_G;
      default:       g = PS_H;
    endcase
    return g;
  endfunction

endpackage

/* rtl/rap_stream_if.sv */
interface rap_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rap_ram.sv */
module rap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/regex_action_lr_parser.sv */
// channel   dir   beat                                   handshake
// in_ch     in    one lexeme (token, char, set, action)  valid/ready
// out_ch    out   one command of an accepted expression  valid/ready
// cfg_*     in    number_mode                            cfg_we, no wait
//
// A reduction reads its rule body and the state below it from the stack RAM,
// then writes the reduced entry back. Action tagging does a read-modify-write
// of the command RAM per tagged command. Streaming reads each command, then
// loads it into the output register. Reset (synchronous, rst_n low) leaves
// one stack entry in the start state; no RAM sweep is needed. out_ch stalls
// hold the streamer only.
module regex_action_lr_parser
  import rap_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int BUF_DEPTH   = 64,
  parameter int INDEX_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  rap_stream_if.sink         in_ch,
  rap_stream_if.source       out_ch,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int IW         = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int SPW        = $clog2(STACK_DEPTH + 1);
  localparam int SAW        = $clog2(STACK_DEPTH);
  localparam int CW         = $clog2(BUF_DEPTH + 1);
  localparam int BAW        = $clog2(BUF_DEPTH);
  localparam int MOVE_LIMIT = 8 * STACK_DEPTH + 64;
  localparam int MVW        = $clog2(MOVE_LIMIT + 1);

  typedef struct packed {
    logic [3:0]    code;
    logic [7:0]    ch;
    logic          def;
    logic          isact;
    logic [IW-1:0] set;
    logic [IW-1:0] act;
  } lex_t;

  typedef struct packed {
    logic [4:0] st;
    lex_t       lx;
    logic [5:0] beg;
    logic [5:0] fin;
  } ent_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [7:0]    ch;
    logic [5:0]    first;
    logic [5:0]    second;
    logic [IW-1:0] set;
    logic [IW-1:0] act;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RDA, S_RDC, S_RED, S_TAGR, S_TAGW, S_SRD, S_SWR
  } state_t;

  state_t     state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [4:0] top_st_r, top_st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0] err_r, err_nxt;
  logic       ovf_r, ovf_nxt;
  logic       nm_r, nm_nxt;
  logic [MVW-1:0] mv_r, mv_nxt;
  lex_t       cur_r, cur_nxt;
  logic [3:0] rr_r, rr_nxt;
  logic       keep_r, keep_nxt;
  logic [1:0] rk_r, rk_nxt;
  ent_t       b_r [3];
  ent_t       b_nxt [3];
  logic [4:0] below_r, below_nxt;
  logic [6:0] tag_i_r, tag_i_nxt;
  logic [5:0] tag_end_r, tag_end_nxt;
  logic [IW-1:0] tag_act_r, tag_act_nxt;
  logic [CW-1:0] str_k_r, str_k_nxt;
  out_item_t  out_r, out_nxt;
  logic       out_v_r, out_v_nxt;

  logic           stk_we, stk_re;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  ent_t           stk_wdata, stk_rdata;
  logic           cmd_we, cmd_re;
  logic [BAW-1:0] cmd_waddr, cmd_raddr;
  cmd_t           cmd_wdata, cmd_rdata;

  rap_ram #(.WIDTH($bits(ent_t)), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  rap_ram #(.WIDTH($bits(cmd_t)), .DEPTH(BUF_DEPTH)) u_cmds (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (cmd_waddr),
    .wdata (cmd_wdata),
    .re    (cmd_re),
    .raddr (cmd_raddr),
    .rdata (cmd_rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  always_comb begin
    logic [3:0]     t;
    logic [7:0]     act;
    logic [1:0]     kind;
    logic [4:0]     arg;
    logic           keep;
    logic           bump;
    lex_t           sh;
    logic           ok;
    logic [1:0]     len;
    logic [SPW-1:0] base;
    logic [SPW-1:0] ridx;
    logic [7:0]     err_inc;
    cmd_t           c;
    logic           emit;
    logic [5:0]     eidx;
    ent_t           ne;
    cmd_t           tw;

    state_nxt   = state_r;
    sp_nxt      = sp_r;
    top_st_nxt  = top_st_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    ovf_nxt     = ovf_r;
    nm_nxt      = cfg_we ? cfg_wdata : nm_r;
    mv_nxt      = mv_r;
    cur_nxt     = cur_r;
    rr_nxt      = rr_r;
    keep_nxt    = keep_r;
    rk_nxt      = rk_r;
    b_nxt       = b_r;
    below_nxt   = below_r;
    tag_i_nxt   = tag_i_r;
    tag_end_nxt = tag_end_r;
    tag_act_nxt = tag_act_r;
    str_k_nxt   = str_k_r;
    out_nxt     = out_r;
    out_v_nxt   = (out_v_r && out_ch.ready) ? 1'b0 : out_v_r;

    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = '0;
    cmd_we    = 1'b0;
    cmd_waddr = '0;
    cmd_wdata = '0;
    cmd_re    = 1'b0;
    cmd_raddr = '0;

    err_inc = (err_r == 8'hFF) ? err_r : err_r + 8'd1;
    len     = RULE_LEN[rr_r];
    base    = sp_r - SPW'(len);

    t    = TERM_OF[cur_r.code];
    act  = ACT_TBL[top_st_r][t];
    kind = act[7:6];
    arg  = act[4:0];
    keep = (kind == AK_RD);
    bump = 1'b0;
    sh   = cur_r;
    ok   = 1'b0;
    ridx = '0;
    c    = '0;
    emit = 1'b0;
    eidx = '0;
    ne   = '0;
    tw   = cmd_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_nxt.code  = in_ch.data.token_kind;
          cur_nxt.ch    = in_ch.data.char_value;
          cur_nxt.set   = in_ch.data.set_index[IW-1:0];
          cur_nxt.act   = in_ch.data.action_index[IW-1:0];
          cur_nxt.def   = in_ch.data.action_defined;
          cur_nxt.isact = in_ch.data.is_action_kind;
          mv_nxt        = '0;
          state_nxt     = S_DEC;
        end
      end

      S_DEC: begin
        if (kind == AK_ER) begin
          case (top_st_r)
            PS_START: begin
              bump    = 1'b1;
              keep    = (t != TM_RPAREN);
              sh.code = TK_LBRACE;
              kind    = AK_SH;
              arg     = PS_LBRACE;
            end
            PS_DONE: kind = AK_ACC;
            PS_LBRACE, PS_LPAREN, PS_BAR: begin
              bump    = 1'b1;
              keep    = 1'b1;
              sh.code = TK_CHAR;
              sh.ch   = FILL_CHAR;
              kind    = AK_SH;
              arg     = PS_LEAF;
            end
            PS_BODY, PS_INNER: begin
              // insert '|'; drop what can never pass here
              bump    = 1'b1;
              keep    = !(t == TM_LBRACE || (top_st_r == PS_BODY && t == TM_RPAREN) ||
                          (top_st_r == PS_INNER && t == TM_RBRACE));
              sh.code = TK_BAR;
              kind    = AK_SH;
              arg     = PS_BAR;
            end
            PS_RBRACE: begin
              kind = AK_RD;
              arg  = {1'b0, R_ACCEPT};
              keep = 1'b1;
            end
            default: begin
              kind = AK_RD;
              arg  = {1'b0, forced_rule(top_st_r)};
              bump = (top_st_r == PS_H || top_st_r == PS_LEAF || top_st_r == PS_RPAREN);
              keep = (top_st_r == PS_E || top_st_r == PS_F || top_st_r == PS_EF ||
                      top_st_r == PS_GPOST || top_st_r == PS_ALT) && (t != TM_BAR);
            end
          endcase
        end

        if (mv_r == MVW'(MOVE_LIMIT)) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (kind)
            AK_ACC: begin
              str_k_nxt = '0;
              state_nxt = S_SRD;
            end
            AK_SH: begin
              ok = (sp_r < SPW'(STACK_DEPTH));
              if (ok) begin
                stk_we    = 1'b1;
                stk_waddr = sp_r[SAW-1:0];
                stk_wdata = '{st: arg, lx: sh, beg: 6'd0, fin: 6'd0};
                sp_nxt    = sp_r + 1'b1;
                top_st_nxt = arg;
              end else begin
                ovf_nxt = 1'b1;
              end
              if (bump || (nm_r && sh.code == TK_COMPL)) err_nxt = err_inc;
              mv_nxt    = mv_r + 1'b1;
              state_nxt = (ok && keep) ? S_DEC : S_IDLE;
            end
            default: begin
              if (bump) err_nxt = err_inc;
              if (sp_r < SPW'(RULE_LEN[arg[3:0]]) + 1'b1) begin
                // stack too shallow for the rule: restart the expression
                sp_nxt     = SPW'(1);
                top_st_nxt = PS_START;
                cnt_nxt    = '0;
                err_nxt    = '0;
                ovf_nxt    = 1'b0;
                mv_nxt     = mv_r + 1'b1;
                state_nxt  = keep ? S_DEC : S_IDLE;
              end else begin
                rr_nxt    = arg[3:0];
                keep_nxt  = keep;
                rk_nxt    = '0;
                state_nxt = S_RDA;
              end
            end
          endcase
        end
      end

      S_RDA: begin
        ridx      = (rk_r == len) ? base - 1'b1 : base + SPW'(rk_r);
        stk_re    = 1'b1;
        stk_raddr = ridx[SAW-1:0];
        state_nxt = S_RDC;
      end

      S_RDC: begin
        if (rk_r == len) begin
          // entry 0 only ever holds the start state
          below_nxt = (base == SPW'(1)) ? PS_START : stk_rdata.st;
          state_nxt = S_RED;
        end else begin
          b_nxt[rk_r] = stk_rdata;
          rk_nxt      = rk_r + 1'b1;
          state_nxt   = S_RDA;
        end
      end

      S_RED: begin
        case (rr_r)
          R_OR, R_CAT: begin
            c.kind   = (rr_r == R_OR) ? CK_OR : CK_CAT;
            c.first  = b_r[0].fin;
            c.second = (rr_r == R_OR) ? b_r[2].fin : b_r[1].fin;
            emit     = 1'b1;
          end
          R_POST: begin
            c.kind  = (b_r[1].lx.code == TK_PLUS)  ? CK_PLUS :
                      (b_r[1].lx.code == TK_QUEST) ? CK_QUEST : CK_STAR;
            c.first = b_r[0].fin;
            emit    = 1'b1;
          end
          R_LEAF: begin
            if (b_r[0].lx.code == TK_COMPL || b_r[0].lx.code == TK_CLASS) begin
              c.kind = (b_r[0].lx.code == TK_COMPL) ? CK_COMPL : CK_CLASS;
              c.set  = b_r[0].lx.set;
            end else begin
              c.kind = CK_CHAR;
              c.ch   = b_r[0].lx.ch;
            end
            emit = 1'b1;
          end
          default: emit = 1'b0;
        endcase

        eidx = (cnt_r < CW'(BUF_DEPTH)) ? 6'(cnt_r) : 6'(BUF_DEPTH - 1);
        if (emit) begin
          if (cnt_r < CW'(BUF_DEPTH)) begin
            cmd_we    = 1'b1;
            cmd_waddr = cnt_r[BAW-1:0];
            cmd_wdata = c;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end

        ne = (rr_r == R_ACCEPT || rr_r == R_PAREN) ? b_r[1] : b_r[0];
        if (rr_r == R_LEAF) ne.beg = eidx;
        if (emit) ne.fin = eidx;
        ne.st = goto_state(rr_r, below_r);

        stk_we     = 1'b1;
        stk_waddr  = base[SAW-1:0];
        stk_wdata  = ne;
        sp_nxt     = base + 1'b1;
        top_st_nxt = ne.st;

        if (rr_r == R_ACT && b_r[1].lx.def && b_r[1].lx.isact) begin
          tag_i_nxt   = {1'b0, b_r[0].beg};
          tag_end_nxt = b_r[0].fin;
          tag_act_nxt = b_r[1].lx.act;
          state_nxt   = S_TAGR;
        end else begin
          if (rr_r == R_ACT) err_nxt = err_inc;
          mv_nxt    = mv_r + 1'b1;
          state_nxt = keep_r ? S_DEC : S_IDLE;
        end
      end

      S_TAGR: begin
        if (tag_i_r > {1'b0, tag_end_r} || tag_i_r >= 7'(cnt_r)) begin
          mv_nxt    = mv_r + 1'b1;
          state_nxt = keep_r ? S_DEC : S_IDLE;
        end else begin
          cmd_re    = 1'b1;
          cmd_raddr = tag_i_r[BAW-1:0];
          state_nxt = S_TAGW;
        end
      end

      S_TAGW: begin
        tw.act    = tag_act_r;
        cmd_we    = 1'b1;
        cmd_waddr = tag_i_r[BAW-1:0];
        cmd_wdata = tw;
        tag_i_nxt = tag_i_r + 1'b1;
        state_nxt = S_TAGR;
      end

      S_SRD: begin
        if (str_k_r == cnt_r) begin
          sp_nxt     = SPW'(1);
          top_st_nxt = PS_START;
          cnt_nxt    = '0;
          err_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end else begin
          cmd_re    = 1'b1;
          cmd_raddr = str_k_r[BAW-1:0];
          state_nxt = S_SWR;
        end
      end

      S_SWR: begin
        // hold until the output register is free
        if (!out_v_r || out_ch.ready) begin
          out_nxt.cmd_kind    = cmd_rdata.kind;
          out_nxt.cmd_char    = cmd_rdata.ch;
          out_nxt.cmd_set     = 16'(cmd_rdata.set);
          out_nxt.cmd_first   = cmd_rdata.first;
          out_nxt.cmd_second  = cmd_rdata.second;
          out_nxt.cmd_action  = 16'(cmd_rdata.act);
          out_nxt.last        = (CW'(str_k_r + 1'b1) == cnt_r);
          out_nxt.error_total = err_r;
          out_nxt.overflow    = ovf_r;
          out_v_nxt           = 1'b1;
          str_k_nxt           = str_k_r + 1'b1;
          state_nxt           = S_SRD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mv_r      <= mv_nxt;
    cur_r     <= cur_nxt;
    rr_r      <= rr_nxt;
    keep_r    <= keep_nxt;
    rk_r      <= rk_nxt;
    b_r       <= b_nxt;
    below_r   <= below_nxt;
    tag_i_r   <= tag_i_nxt;
    tag_end_r <= tag_end_nxt;
    tag_act_r <= tag_act_nxt;
    str_k_r   <= str_k_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sp_r     <= SPW'(1);
      top_st_r <= PS_START;
      cnt_r    <= '0;
      err_r    <= '0;
      ovf_r    <= 1'b0;
      nm_r     <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      top_st_r <= top_st_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      ovf_r    <= ovf_nxt;
      nm_r     <= nm_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

endmodule
